[design/fsta_pkg.sv]
// shared types and constants for the fan and strip triangle assembler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsta_pkg;

    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLY_TEX_BY_CELL  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIP_TEX_BY_CELL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NORMALS_ON        = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEXCOORDS_ON      = 2'd3;

    // primitive kinds
    localparam logic CMD_POLY  = 1'b0;
    localparam logic CMD_STRIP = 1'b1;

    localparam logic [1:0] SEEN_MAX = 2'd3;

    typedef struct packed {
        logic poly_tex_by_cell;
        logic strip_tex_by_cell;
        logic normals_on;
        logic texcoords_on;
    } t_cfg;

    typedef struct packed {
        logic normals_valid;
        logic tex_valid;
        logic from_strip;
    } t_flags;

endpackage

`default_nettype wire

[design/fsta_cfg.sv]
// configuration register file for the triangle assembler
// depends on fsta_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsta_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fsta_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic                              i_cfg_data,
    output fsta_pkg::t_cfg                         o_cfg
);

    fsta_pkg::t_cfg r_cfg;
    fsta_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                fsta_pkg::CFG_POLY_TEX_BY_CELL:  n_cfg.poly_tex_by_cell  = i_cfg_data;
                fsta_pkg::CFG_STRIP_TEX_BY_CELL: n_cfg.strip_tex_by_cell = i_cfg_data;
                fsta_pkg::CFG_NORMALS_ON:        n_cfg.normals_on        = i_cfg_data;
                fsta_pkg::CFG_TEXCOORDS_ON:      n_cfg.texcoords_on      = i_cfg_data;
                default:                         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

[design/fsta_core.sv]
// triangle forming logic and per-cell vertex history
// depends on fsta_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsta_core #(
    parameter int INDEX_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_go,
    input  wire logic                  i_cmd,
    input  wire logic [INDEX_BITS-1:0] i_vertex,
    input  wire logic                  i_first_in_cell,
    input  wire logic                  i_first_cell_of_list,
    input  wire fsta_pkg::t_cfg        i_cfg,
    output logic                       o_emit,
    output logic [INDEX_BITS-1:0]      o_vert_a,
    output logic [INDEX_BITS-1:0]      o_vert_b,
    output logic [INDEX_BITS-1:0]      o_vert_c,
    output logic [INDEX_BITS-1:0]      o_tex_a,
    output logic [INDEX_BITS-1:0]      o_tex_b,
    output logic [INDEX_BITS-1:0]      o_tex_c,
    output fsta_pkg::t_flags           o_flags,
    output logic [INDEX_BITS-1:0]      o_cell_number
);

    localparam logic [INDEX_BITS-1:0] ONE = {{(INDEX_BITS-1){1'b0}}, 1'b1};

    logic [INDEX_BITS-1:0] r_anchor, r_corner_one, r_corner_two, r_cell_cnt;
    logic [1:0]            r_seen;
    logic                  r_parity;

    logic [INDEX_BITS-1:0] n_anchor, n_cell_cnt;
    logic [1:0]            n_seen;
    logic                  n_parity;

    logic [1:0]            seen_eff;
    logic                  parity_eff;
    logic                  by_cell;

    always_comb begin
        if (i_first_in_cell) begin
            seen_eff   = 2'd0;
            parity_eff = 1'b0;
            n_cell_cnt = i_first_cell_of_list ? '0 : r_cell_cnt + ONE;
        end else begin
            seen_eff   = r_seen;
            parity_eff = r_parity;
            n_cell_cnt = r_cell_cnt;
        end

        // third vertex of a cell and on closes a triangle
        o_emit = seen_eff[1];

        if (i_cmd == fsta_pkg::CMD_POLY) begin
            o_vert_a = r_anchor;
            o_vert_b = r_corner_two;
            o_vert_c = i_vertex;
        end else if (!parity_eff) begin
            o_vert_a = r_corner_one;
            o_vert_b = r_corner_two;
            o_vert_c = i_vertex;
        end else begin
            o_vert_a = r_corner_one;
            o_vert_b = i_vertex;
            o_vert_c = r_corner_two;
        end

        by_cell = (i_cmd == fsta_pkg::CMD_STRIP) ? i_cfg.strip_tex_by_cell
                                                 : i_cfg.poly_tex_by_cell;
        if (!i_cfg.texcoords_on) begin
            o_tex_a = '0;
            o_tex_b = '0;
            o_tex_c = '0;
        end else if (by_cell) begin
            o_tex_a = n_cell_cnt;
            o_tex_b = n_cell_cnt;
            o_tex_c = n_cell_cnt;
        end else begin
            o_tex_a = o_vert_a;
            o_tex_b = o_vert_b;
            o_tex_c = o_vert_c;
        end

        o_flags.normals_valid = i_cfg.normals_on;
        o_flags.tex_valid     = i_cfg.texcoords_on;
        o_flags.from_strip    = i_cmd;
        o_cell_number         = n_cell_cnt;

        n_anchor = (seen_eff == 2'd0) ? i_vertex : r_anchor;
        n_seen   = (seen_eff == fsta_pkg::SEEN_MAX) ? seen_eff : seen_eff + 2'd1;
        n_parity = o_emit ? ~parity_eff : parity_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor     <= '0;
            r_corner_one <= '0;
            r_corner_two <= '0;
            r_cell_cnt   <= '0;
            r_seen       <= 2'd0;
            r_parity     <= 1'b0;
        end else if (i_go) begin
            r_anchor     <= n_anchor;
            r_corner_one <= r_corner_two;
            r_corner_two <= i_vertex;
            r_cell_cnt   <= n_cell_cnt;
            r_seen       <= n_seen;
            r_parity     <= n_parity;
        end
    end

endmodule

`default_nettype wire

[design/fan_and_strip_triangle_assembler.sv]
// triangle assembler top: input register, forming logic, result register
// depends on fsta_pkg, fsta_cfg, fsta_core
// a vertex is held in the input register, then the triangle it closes in the result register
// throughput: a new vertex each cycle while the result side keeps up
// a vertex that closes no triangle never waits on the result register
// reset (synchronous, active low) clears config, cell state and both valids
`timescale 1ns / 1ps
`default_nettype none

module fan_and_strip_triangle_assembler #(
    parameter int INDEX_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // vertex input
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_cmd,
    input  wire logic [INDEX_BITS-1:0]             i_vertex_index,
    input  wire logic                              i_first_in_cell,
    input  wire logic                              i_first_cell_of_list,
    // triangle output
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [INDEX_BITS-1:0]                  o_vert_a,
    output logic [INDEX_BITS-1:0]                  o_vert_b,
    output logic [INDEX_BITS-1:0]                  o_vert_c,
    output logic [INDEX_BITS-1:0]                  o_tex_a,
    output logic [INDEX_BITS-1:0]                  o_tex_b,
    output logic [INDEX_BITS-1:0]                  o_tex_c,
    output logic                                   o_normals_valid,
    output logic                                   o_tex_valid,
    output logic                                   o_from_strip,
    output logic [INDEX_BITS-1:0]                  o_cell_number,
    // configuration
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fsta_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic                              i_cfg_data
);

    fsta_pkg::t_cfg   cfg;
    fsta_pkg::t_flags core_flags;
    fsta_pkg::t_flags r_out_flags;

    logic                  r_s1_valid;
    logic                  r_s1_cmd, r_s1_first_in_cell, r_s1_first_cell_of_list;
    logic [INDEX_BITS-1:0] r_s1_vertex;

    logic                  core_emit;
    logic [INDEX_BITS-1:0] core_vert_a, core_vert_b, core_vert_c;
    logic [INDEX_BITS-1:0] core_tex_a, core_tex_b, core_tex_c, core_cell_number;

    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_vert_a, r_out_vert_b, r_out_vert_c;
    logic [INDEX_BITS-1:0] r_out_tex_a, r_out_tex_b, r_out_tex_c, r_out_cell_number;

    logic out_free, s1_go, in_xfer, out_load;

    fsta_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsta_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_go                 (s1_go),
        .i_cmd                (r_s1_cmd),
        .i_vertex             (r_s1_vertex),
        .i_first_in_cell      (r_s1_first_in_cell),
        .i_first_cell_of_list (r_s1_first_cell_of_list),
        .i_cfg                (cfg),
        .o_emit               (core_emit),
        .o_vert_a             (core_vert_a),
        .o_vert_b             (core_vert_b),
        .o_vert_c             (core_vert_c),
        .o_tex_a              (core_tex_a),
        .o_tex_b              (core_tex_b),
        .o_tex_c              (core_tex_c),
        .o_flags              (core_flags),
        .o_cell_number        (core_cell_number)
    );

    // result register can take a new triangle this cycle
    assign out_free = !r_out_valid || !i_stall;
    // vertices that close no triangle pass through regardless of the output side
    assign s1_go    = r_s1_valid && (!core_emit || out_free);
    assign out_load = s1_go && core_emit;
    assign o_stall  = r_s1_valid && !s1_go;
    assign in_xfer  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= out_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd                <= i_cmd;
            r_s1_vertex             <= i_vertex_index;
            r_s1_first_in_cell      <= i_first_in_cell;
            r_s1_first_cell_of_list <= i_first_cell_of_list;
        end
        if (out_load) begin
            r_out_vert_a      <= core_vert_a;
            r_out_vert_b      <= core_vert_b;
            r_out_vert_c      <= core_vert_c;
            r_out_tex_a       <= core_tex_a;
            r_out_tex_b       <= core_tex_b;
            r_out_tex_c       <= core_tex_c;
            r_out_flags       <= core_flags;
            r_out_cell_number <= core_cell_number;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_vert_a        = r_out_vert_a;
    assign o_vert_b        = r_out_vert_b;
    assign o_vert_c        = r_out_vert_c;
    assign o_tex_a         = r_out_tex_a;
    assign o_tex_b         = r_out_tex_b;
    assign o_tex_c         = r_out_tex_c;
    assign o_normals_valid = r_out_flags.normals_valid;
    assign o_tex_valid     = r_out_flags.tex_valid;
    assign o_from_strip    = r_out_flags.from_strip;
    assign o_cell_number   = r_out_cell_number;

    // a held vertex keeps its payload until the core takes it
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_vertex)))
        else $error("input register lost a held vertex");

    // a triangle is never formed while the result register is full and stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_go && core_emit && !out_free))
        else $error("triangle dropped on full result register");

    // texture indices read zero whenever they are flagged invalid
    a_tex_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tex_valid) |-> (o_tex_a == '0 && o_tex_b == '0 && o_tex_c == '0))
        else $error("texture indices set while texture flag is low");

    // a stalled input means a vertex that closes a triangle is pending while the result register is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && core_emit && r_out_valid && i_stall))
        else $error("input stalled without a blocked triangle");

endmodule

`default_nettype wire

[dv/tb_fan_and_strip_triangle_assembler.sv]
// self-checking testbench for fan_and_strip_triangle_assembler: vertex stream in, triangles out
// keeps its own cell/corner state to predict each triangle; depends on fsta_pkg and the block
`timescale 1ns / 1ps

module tb_fan_and_strip_triangle_assembler;

    localparam int IB = 24;
    localparam int SETTLE_CYCLES = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [IB-1:0] vert_a;
        logic [IB-1:0] vert_b;
        logic [IB-1:0] vert_c;
        logic [IB-1:0] tex_a;
        logic [IB-1:0] tex_b;
        logic [IB-1:0] tex_c;
        logic          normals_valid;
        logic          tex_valid;
        logic          from_strip;
        logic [IB-1:0] cell_number;
    } t_tri;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic                              i_cmd = fsta_pkg::CMD_POLY;
    logic [IB-1:0]                     i_vertex_index = '0;
    logic                              i_first_in_cell = 1'b0;
    logic                              i_first_cell_of_list = 1'b0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [IB-1:0]                     o_vert_a, o_vert_b, o_vert_c;
    logic [IB-1:0]                     o_tex_a, o_tex_b, o_tex_c;
    logic                              o_normals_valid, o_tex_valid, o_from_strip;
    logic [IB-1:0]                     o_cell_number;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [fsta_pkg::CFG_IDX_BITS-1:0] i_cfg_index = fsta_pkg::CFG_POLY_TEX_BY_CELL;
    logic                              i_cfg_data = 1'b0;

    fan_and_strip_triangle_assembler #(.INDEX_BITS(IB)) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_cmd                (i_cmd),
        .i_vertex_index       (i_vertex_index),
        .i_first_in_cell      (i_first_in_cell),
        .i_first_cell_of_list (i_first_cell_of_list),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_vert_a             (o_vert_a),
        .o_vert_b             (o_vert_b),
        .o_vert_c             (o_vert_c),
        .o_tex_a              (o_tex_a),
        .o_tex_b              (o_tex_b),
        .o_tex_c              (o_tex_c),
        .o_normals_valid      (o_normals_valid),
        .o_tex_valid          (o_tex_valid),
        .o_from_strip         (o_from_strip),
        .o_cell_number        (o_cell_number),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block's configuration and cell state
    fsta_pkg::t_cfg cfg_shadow = '0;
    logic [IB-1:0]  anchor_vert = '0;
    logic [IB-1:0]  older_vert = '0;
    logic [IB-1:0]  newest_vert = '0;
    logic [1:0]     cell_seen = '0;
    logic           winding_odd = 1'b0;
    logic [IB-1:0]  cell_count = '0;

    t_tri pending_tris[$];
    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   rcv_stall_pct = 0;
    int   quiet_cycles = 0;

    always @(posedge i_clk) begin
        i_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
    end

    // update the shadow state for one vertex and queue the triangle it closes, if any
    task automatic assemble_vertex(input logic cmd, input logic [IB-1:0] v,
                                   input logic opens_cell, input logic opens_list);
        t_tri t;
        logic by_cell;
        if (opens_cell) begin
            cell_seen = '0;
            winding_odd = 1'b0;
            cell_count = opens_list ? '0 : cell_count + 1'b1;
        end
        if (cell_seen == 2'd0) begin
            anchor_vert = v;
        end else if (cell_seen >= 2'd2) begin
            if (cmd == fsta_pkg::CMD_POLY) begin
                t.vert_a = anchor_vert; t.vert_b = newest_vert; t.vert_c = v;
            end else if (!winding_odd) begin
                t.vert_a = older_vert; t.vert_b = newest_vert; t.vert_c = v;
            end else begin
                t.vert_a = older_vert; t.vert_b = v; t.vert_c = newest_vert;
            end
            by_cell = (cmd == fsta_pkg::CMD_STRIP) ? cfg_shadow.strip_tex_by_cell
                                                   : cfg_shadow.poly_tex_by_cell;
            if (!cfg_shadow.texcoords_on) begin
                t.tex_a = '0; t.tex_b = '0; t.tex_c = '0;
            end else if (by_cell) begin
                t.tex_a = cell_count; t.tex_b = cell_count; t.tex_c = cell_count;
            end else begin
                t.tex_a = t.vert_a; t.tex_b = t.vert_b; t.tex_c = t.vert_c;
            end
            t.normals_valid = cfg_shadow.normals_on;
            t.tex_valid = cfg_shadow.texcoords_on;
            t.from_strip = cmd;
            t.cell_number = cell_count;
            pending_tris = {pending_tris, t};
            winding_odd = ~winding_odd;
        end
        older_vert = newest_vert;
        newest_vert = v;
        if (cell_seen < fsta_pkg::SEEN_MAX) cell_seen = cell_seen + 1'b1;
    endtask

    task automatic check_field(input string name, input logic [IB-1:0] want,
                               input logic [IB-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %h got %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_tri t;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_tris.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected triangle %h %h %h", $realtime,
                             o_vert_a, o_vert_b, o_vert_c);
            end else begin
                t = pending_tris.pop_front();
                check_field("vert_a", t.vert_a, o_vert_a);
                check_field("vert_b", t.vert_b, o_vert_b);
                check_field("vert_c", t.vert_c, o_vert_c);
                check_field("tex_a", t.tex_a, o_tex_a);
                check_field("tex_b", t.tex_b, o_tex_b);
                check_field("tex_c", t.tex_c, o_tex_c);
                check_field("normals_valid", IB'(t.normals_valid), IB'(o_normals_valid));
                check_field("tex_valid", IB'(t.tex_valid), IB'(o_tex_valid));
                check_field("from_strip", IB'(t.from_strip), IB'(o_from_strip));
                check_field("cell_number", t.cell_number, o_cell_number);
            end
        end
    end

    // ends the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_vertex(input logic cmd, input logic [IB-1:0] v,
                               input logic opens_cell, input logic opens_list);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_vertex_index <= v;
        i_first_in_cell <= opens_cell;
        i_first_cell_of_list <= opens_list;
        do @(posedge i_clk); while (o_stall);
        assemble_vertex(cmd, v, opens_cell, opens_list);
    endtask

    // stop sending, let every queued triangle out, then allow for vertices still in flight
    task automatic wait_until_idle();
        i_valid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fsta_pkg::CFG_IDX_BITS-1:0] idx, input logic data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fsta_pkg::CFG_POLY_TEX_BY_CELL:  cfg_shadow.poly_tex_by_cell = data;
            fsta_pkg::CFG_STRIP_TEX_BY_CELL: cfg_shadow.strip_tex_by_cell = data;
            fsta_pkg::CFG_NORMALS_ON:        cfg_shadow.normals_on = data;
            fsta_pkg::CFG_TEXCOORDS_ON:      cfg_shadow.texcoords_on = data;
            default: ;
        endcase
    endtask

    task automatic load_config(input fsta_pkg::t_cfg c);
        wait_until_idle();
        write_reg(fsta_pkg::CFG_POLY_TEX_BY_CELL, c.poly_tex_by_cell);
        write_reg(fsta_pkg::CFG_STRIP_TEX_BY_CELL, c.strip_tex_by_cell);
        write_reg(fsta_pkg::CFG_NORMALS_ON, c.normals_on);
        write_reg(fsta_pkg::CFG_TEXCOORDS_ON, c.texcoords_on);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [IB-1:0] rand_index();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return IB'($urandom);
        endcase
    endfunction

    // vertices before any cell mark extend the empty cell after reset
    task automatic test_unmarked_start();
        send_vertex(fsta_pkg::CMD_POLY, 24'd5, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'd6, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'd7, 1'b0, 1'b0);
    endtask

    // one- and two-vertex cells close nothing; a list mark alone is ignored
    task automatic test_short_cells();
        send_vertex(fsta_pkg::CMD_STRIP, 24'd9, 1'b1, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'd10, 1'b1, 1'b1);
        send_vertex(fsta_pkg::CMD_POLY, 24'd11, 1'b0, 1'b1);
    endtask

    task automatic test_poly_fan();
        send_vertex(fsta_pkg::CMD_POLY, '0, 1'b1, 1'b1);
        send_vertex(fsta_pkg::CMD_POLY, '1, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'h123456, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, '0, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, '1, 1'b0, 1'b0);
    endtask

    task automatic test_strip_winding();
        send_vertex(fsta_pkg::CMD_STRIP, 24'h000001, 1'b1, 1'b0);
        send_vertex(fsta_pkg::CMD_STRIP, 24'hfffffe, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_STRIP, 24'h000003, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_STRIP, 24'h800000, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_STRIP, 24'h7fffff, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_STRIP, 24'h555555, 1'b0, 1'b0);
    endtask

    // kind switches inside a cell; winding parity keeps counting across them
    task automatic test_mixed_kinds();
        send_vertex(fsta_pkg::CMD_STRIP, 24'h000100, 1'b1, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'h000200, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'h000300, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_STRIP, 24'h000400, 1'b0, 1'b0);
        send_vertex(fsta_pkg::CMD_POLY, 24'h000500, 1'b0, 1'b0);
    endtask

    // mostly whole cells of random kind and length, some stray marks and lone vertices
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int   sent;
        int   len;
        logic kind;
        logic mixed;
        logic list_mark;
        sent = 0;
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(9, 3);
                kind = logic'($urandom_range(1));
                mixed = ($urandom_range(9) == 0);
                list_mark = ($urandom_range(4) == 0);
                for (int k = 0; k < len; k++) begin
                    send_vertex(mixed ? logic'($urandom_range(1)) : kind, rand_index(),
                                k == 0, (k == 0) ? list_mark : ($urandom_range(15) == 0));
                end
                sent += len;
            end else begin
                send_vertex(logic'($urandom_range(1)), rand_index(),
                            logic'($urandom_range(1)), logic'($urandom_range(1)));
                sent++;
            end
            if ($urandom_range(39) == 0) wait_until_idle();
        end
        send_idle_pct = 0;
        rcv_stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unmarked_start();
        test_short_cells();
        load_config('{poly_tex_by_cell: 1'b1, strip_tex_by_cell: 1'b0,
                      normals_on: 1'b1, texcoords_on: 1'b1});
        test_poly_fan();
        test_strip_winding();
        load_config('{poly_tex_by_cell: 1'b0, strip_tex_by_cell: 1'b1,
                      normals_on: 1'b0, texcoords_on: 1'b1});
        test_mixed_kinds();

        load_config('1);
        test_random_traffic(165, 0, 0);
        load_config('{poly_tex_by_cell: 1'b1, strip_tex_by_cell: 1'b0,
                      normals_on: 1'b1, texcoords_on: 1'b1});
        test_random_traffic(165, 63, 0);
        load_config('{poly_tex_by_cell: 1'b0, strip_tex_by_cell: 1'b1,
                      normals_on: 1'b0, texcoords_on: 1'b1});
        test_random_traffic(165, 0, 63);
        load_config('0);
        test_random_traffic(165, 6, 6);

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/fsta_pkg.sv
design/fsta_cfg.sv
design/fsta_core.sv
design/fan_and_strip_triangle_assembler.sv
dv/tb_fan_and_strip_triangle_assembler.sv
